@@ hdl/fbecho_pkg.sv @@
// Constants shared by the feedback echo delay line.
package fbecho_pkg;

  // Ring store geometry; the pointer wraps by natural overflow, so the depth is a power of two
  localparam int RING_DEPTH  = 131072;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int SAMPLE_BITS = 24;

  // Register widths and indexes
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int DELAY_W    = 10;
  localparam int PCT_W      = 7;
  localparam int RATE_W     = 16;
  localparam int CHAN_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd4;

  localparam logic [DELAY_W-1:0] DELAY_RST    = 10'd500;
  localparam logic [PCT_W-1:0]   FEEDBACK_RST = 7'd50;
  localparam logic [PCT_W-1:0]   VOLUME_RST   = 7'd50;
  localparam logic [RATE_W-1:0]  RATE_RST     = 16'd44100;
  localparam logic [CHAN_W-1:0]  CHAN_RST     = 2'd2;

  // rate*delay product and its quotient by 1000
  localparam int RD_PROD_W = RATE_W + DELAY_W;
  localparam int MS_Q_W    = 17;
  // ceil(2^36/1000): exact floor division for any 26-bit dividend
  localparam int RECIP_1000_SH = 36;
  localparam int RECIP_1000_W  = 27;
  localparam logic [RECIP_1000_W-1:0] RECIP_1000 = 27'd68719477;

  // tap*pct magnitude and its quotient by 100
  localparam int TAP_PROD_W = SAMPLE_BITS + PCT_W + 1;
  localparam int TAP_MAG_W  = SAMPLE_BITS + PCT_W - 1;
  // ceil(2^37/100): exact floor division for any 30-bit dividend
  localparam int RECIP_100_SH = 37;
  localparam int RECIP_100_W  = 31;
  localparam logic [RECIP_100_W-1:0] RECIP_100 = 31'd1374389535;
  localparam int PCT_Q_W = TAP_MAG_W + RECIP_100_W - RECIP_100_SH;

  localparam int SUM_W = SAMPLE_BITS + 2;

  // Cycles after a register write until the tap distance is settled
  localparam int SETTLE_W = 2;
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

  // Output queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

endpackage

@@ hdl/feedback_echo_delay_line_top.sv @@
// Feedback echo delay line: ring store read-modify-write with output queue.
//
// One signed 24-bit interleaved sample enters per transaction on s_*, and one echoed sample
// leaves per transaction on m_*. The tap distance D = (sample_rate*delay_ms/1000)*channel_count
// (mod 131072) is worked out by a three-stage pipeline, and the input holds off after any
// register write until that pipeline has settled. A sample runs four stages from the ring
// memory read to the write-back, so a new sample is taken every cycle when D is 0 or at least
// 4, while no write is settling and the output queue has room; for D of 1 to 3 the sample
// that needs a value still in flight waits until that value reaches the write-back stage.
// Results enter an eight-entry output queue from the write-back stage; the input keeps
// flowing while results wait there, until eight samples are queued or in flight.
// The ring store is not swept after reset or after a rate or channel change: a fill mark
// tracks which entries were written since, and entries not yet written read as zero.
module feedback_echo_delay_line_top
  import fbecho_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [23:0]            s_tdata,   // [23:0] sample_in
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [23:0]            m_tdata,   // [23:0] sample_out
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  function automatic logic [SAMPLE_BITS-1:0] saturate(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      saturate = hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      saturate = lo[SAMPLE_BITS-1:0];
    end else begin
      saturate = v[SAMPLE_BITS-1:0];
    end
  endfunction

  // ---------------- configuration ----------------
  logic [DELAY_W-1:0]  delay_ms;
  logic [PCT_W-1:0]    feedback_pct;
  logic [PCT_W-1:0]    volume_pct;
  logic [RATE_W-1:0]   sample_rate;
  logic [CHAN_W-1:0]   channel_count;
  logic [SETTLE_W-1:0] settle;
  logic                clear_req;

  always_comb begin
    clear_req = 1'b0;
    if (cfg_we) begin
      if (cfg_index == REG_RATE && cfg_data[RATE_W-1:0] != sample_rate) begin
        clear_req = 1'b1;
      end
      if (cfg_index == REG_CHANNELS && cfg_data[CHAN_W-1:0] != channel_count) begin
        clear_req = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ms      <= DELAY_RST;
      feedback_pct  <= FEEDBACK_RST;
      volume_pct    <= VOLUME_RST;
      sample_rate   <= RATE_RST;
      channel_count <= CHAN_RST;
      settle        <= SETTLE_CYCLES;
    end else begin
      if (cfg_we) begin
        settle <= SETTLE_CYCLES;
        unique case (cfg_index)
          REG_DELAY:    delay_ms      <= cfg_data[DELAY_W-1:0];
          REG_FEEDBACK: feedback_pct  <= cfg_data[PCT_W-1:0];
          REG_VOLUME:   volume_pct    <= cfg_data[PCT_W-1:0];
          REG_RATE:     sample_rate   <= cfg_data[RATE_W-1:0];
          REG_CHANNELS: channel_count <= cfg_data[CHAN_W-1:0];
          default: ;
        endcase
      end else if (settle != '0) begin
        settle <= settle - SETTLE_W'(1);
      end
    end
  end

  // Tap distance: product, reciprocal divide by 1000, channel scale
  logic [RD_PROD_W-1:0]                 rd_prod;
  logic [MS_Q_W-1:0]                    ms_q;
  logic [PTR_W-1:0]                     tap_dist;
  logic [RD_PROD_W+RECIP_1000_W-1:0]    ms_full;
  logic [MS_Q_W+CHAN_W-1:0]             dist_full;

  assign ms_full   = (RD_PROD_W+RECIP_1000_W)'(rd_prod) * (RD_PROD_W+RECIP_1000_W)'(RECIP_1000);
  assign dist_full = (MS_Q_W+CHAN_W)'(ms_q) * (MS_Q_W+CHAN_W)'(channel_count);

  always_ff @(posedge clk) begin
    rd_prod  <= RD_PROD_W'(sample_rate) * RD_PROD_W'(delay_ms);
    ms_q     <= ms_full[RECIP_1000_SH +: MS_Q_W];
    tap_dist <= dist_full[PTR_W-1:0];
  end

  // ---------------- write pointer and fill mark ----------------
  logic [PTR_W-1:0] wp;
  logic             full;
  logic             accept;

  always_ff @(posedge clk) begin
    if (rst || clear_req) begin
      wp   <= '0;
      full <= 1'b0;
    end else if (accept) begin
      wp <= wp + PTR_W'(1);
      if (wp == {PTR_W{1'b1}}) begin
        full <= 1'b1;
      end
    end
  end

  // ---------------- pipeline ----------------
  logic                    v1, v2, v3, v4;
  logic [PTR_W-1:0]        wp1, wp2, wp3, wp4;
  logic [SAMPLE_BITS-1:0]  x1, x2, x3, x4;
  logic                    ok1, fwd1;
  logic [SAMPLE_BITS-1:0]  fwd_data1;
  logic [SAMPLE_BITS-1:0]  mem_q;
  logic signed [TAP_PROD_W-1:0] pv2, pf2;
  logic [TAP_PROD_W-1:0]   nvv, nvf;
  logic [TAP_MAG_W-1:0]    av3, af3;
  logic                    nv3, nf3, nv4, nf4;
  logic [PCT_Q_W-1:0]      qv4, qf4;
  logic [TAP_MAG_W+RECIP_100_W-1:0] mv, mf;
  logic signed [SAMPLE_BITS-1:0] tap1;
  logic signed [SUM_W-1:0] xe, qve, qfe;
  logic [SAMPLE_BITS-1:0]  out_next, store_next;

  logic [PTR_W-1:0] rd;
  logic             tap_ok, hazard, fwd;

  logic [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];

  assign rd     = wp - tap_dist;
  assign tap_ok = full || (rd < wp);
  // Entry still on its way to the ring: wait until it reaches the write-back stage
  assign hazard = tap_ok && ((v1 && wp1 == rd) || (v2 && wp2 == rd) || (v3 && wp3 == rd));
  assign fwd    = v4 && (wp4 == rd);

  // Output queue occupancy plus samples in flight bounds acceptance
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W-1:0] inflight;
  logic [FIFO_CNT_W-1:0] committed;

  assign inflight  = FIFO_CNT_W'(v1) + FIFO_CNT_W'(v2) + FIFO_CNT_W'(v3) + FIFO_CNT_W'(v4);
  assign committed = fifo_count + inflight;
  assign s_tready  = (settle == '0) && !hazard && (committed < FIFO_CNT_W'(FIFO_DEPTH));
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Ring memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q <= ring_mem[rd];
    end
    if (v4) begin
      ring_mem[wp4] <= store_next;
    end
  end

  assign tap1 = !ok1 ? '0 : (fwd1 ? fwd_data1 : mem_q);
  assign nvv  = -pv2;
  assign nvf  = -pf2;
  assign mv   = (TAP_MAG_W+RECIP_100_W)'(av3) * (TAP_MAG_W+RECIP_100_W)'(RECIP_100);
  assign mf   = (TAP_MAG_W+RECIP_100_W)'(af3) * (TAP_MAG_W+RECIP_100_W)'(RECIP_100);

  always_ff @(posedge clk) begin
    // stage 1: read issued, same-cycle write-back captured
    x1        <= s_tdata;
    wp1       <= wp;
    ok1       <= tap_ok;
    fwd1      <= fwd;
    fwd_data1 <= store_next;
    // stage 2: tap times percentages
    x2  <= x1;
    wp2 <= wp1;
    pv2 <= TAP_PROD_W'(tap1) * TAP_PROD_W'($signed({1'b0, volume_pct}));
    pf2 <= TAP_PROD_W'(tap1) * TAP_PROD_W'($signed({1'b0, feedback_pct}));
    // stage 3: sign and magnitude, so the divide truncates toward zero
    x3  <= x2;
    wp3 <= wp2;
    nv3 <= pv2[TAP_PROD_W-1];
    nf3 <= pf2[TAP_PROD_W-1];
    av3 <= pv2[TAP_PROD_W-1] ? nvv[TAP_MAG_W-1:0] : pv2[TAP_MAG_W-1:0];
    af3 <= pf2[TAP_PROD_W-1] ? nvf[TAP_MAG_W-1:0] : pf2[TAP_MAG_W-1:0];
    // stage 4: reciprocal divide by 100
    x4  <= x3;
    wp4 <= wp3;
    nv4 <= nv3;
    nf4 <= nf3;
    qv4 <= mv[RECIP_100_SH +: PCT_Q_W];
    qf4 <= mf[RECIP_100_SH +: PCT_Q_W];
  end

  always_comb begin
    xe  = SUM_W'($signed(x4));
    qve = nv4 ? -$signed(SUM_W'(qv4)) : $signed(SUM_W'(qv4));
    qfe = nf4 ? -$signed(SUM_W'(qf4)) : $signed(SUM_W'(qf4));
    out_next   = saturate(xe + qve);
    store_next = saturate(xe + qfe);
  end

  // ---------------- output queue ----------------
  logic [SAMPLE_BITS-1:0] fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  fifo_wr, fifo_rd;
  logic                   pop;

  assign m_tvalid = (fifo_count != '0);
  assign m_tdata  = fifo_mem[fifo_rd];
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_wr    <= '0;
      fifo_rd    <= '0;
      fifo_count <= '0;
    end else begin
      if (v4) begin
        fifo_wr <= fifo_wr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        fifo_rd <= fifo_rd + FIFO_PTR_W'(1);
      end
      if (v4 && !pop) begin
        fifo_count <= fifo_count + FIFO_CNT_W'(1);
      end else if (pop && !v4) begin
        fifo_count <= fifo_count - FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v4) begin
      fifo_mem[fifo_wr] <= out_next;
    end
  end

endmodule

@@ bench/feedback_echo_delay_line_top_tb.sv @@
// Self-checking bench for the feedback echo delay line: random stream traffic vs. a local echo model.
`timescale 1ns / 1ps

module feedback_echo_delay_line_top_tb
  import fbecho_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 650;
  localparam int QUIET_CYCLES = 16;
  localparam logic [CFG_IDX_W-1:0] REG_IDX_MAX = '1;
  localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  feedback_echo_delay_line_top u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Echo model state
  logic [DELAY_W-1:0] cur_delay = DELAY_RST;
  logic [PCT_W-1:0] cur_fb = FEEDBACK_RST;
  logic [PCT_W-1:0] cur_vol = VOLUME_RST;
  logic [RATE_W-1:0] cur_rate = RATE_RST;
  logic [CHAN_W-1:0] cur_chan = CHAN_RST;
  longint echo_mem[int];
  int wr_ptr = 0;

  logic [23:0] samples_to_send[$];
  logic [23:0] out_due[$];
  bit s_taken = 0;
  bit idle_on = 1;
  int gap_left = 0;
  int stall_left = 0;
  int errors = 0;
  int cycles = 0;

  function automatic longint clamp_sample(longint v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    return v;
  endfunction

  function automatic void clear_ring();
    echo_mem.delete();
    wr_ptr = 0;
  endfunction

  function automatic void reg_update(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_DELAY: cur_delay = val[DELAY_W-1:0];
      REG_FEEDBACK: cur_fb = val[PCT_W-1:0];
      REG_VOLUME: cur_vol = val[PCT_W-1:0];
      REG_RATE: begin
        if (val[RATE_W-1:0] != cur_rate) begin
          cur_rate = val[RATE_W-1:0];
          clear_ring();
        end
      end
      REG_CHANNELS: begin
        if (val[CHAN_W-1:0] != cur_chan) begin
          cur_chan = val[CHAN_W-1:0];
          clear_ring();
        end
      end
      default: ;
    endcase
  endfunction

  // One ring read-modify-write; returns the echoed output sample
  function automatic logic [23:0] echo_step(logic [23:0] din);
    longint x, tap, y, s, tap_dist;
    int rd;
    x = longint'($signed(din));
    tap_dist = ((longint'(cur_rate) * longint'(cur_delay)) / 1000) * longint'(cur_chan);
    tap_dist = tap_dist % RING_DEPTH;
    rd = int'((longint'(wr_ptr) + RING_DEPTH - tap_dist) % RING_DEPTH);
    tap = echo_mem.exists(rd) ? echo_mem[rd] : 0;
    y = clamp_sample(x + (tap * longint'(cur_vol)) / 100);
    s = clamp_sample(x + (tap * longint'(cur_fb)) / 100);
    echo_mem[wr_ptr] = s;
    wr_ptr = (wr_ptr + 1) % RING_DEPTH;
    return y[23:0];
  endfunction

  function automatic logic [23:0] gen_sample();
    logic [23:0] r;
    r = 24'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: r = 24'h800000;
          1: r = 24'h7FFFFF;
          2: r = 24'h000000;
          default: r = 24'hFFFFFF;
        endcase
      end
      1, 2: r = {{12{r[11]}}, r[11:0]};
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [PCT_W-1:0] pick_pct();
    case ($urandom_range(0, 4))
      0: return 7'd0;
      1: return 7'd100;
      2: return 7'd127;
      default: return PCT_W'($urandom_range(0, 127));
    endcase
  endfunction

  // Stream driver: accept side
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      out_due.push_back(echo_step(s_tdata));
      void'(samples_to_send.pop_front());
      s_taken = 1;
    end
  end

  // Stream driver: present side
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !s_taken)) begin
      if (gap_left > 0) begin
        s_tvalid <= 1'b0;
        s_tdata <= 24'($urandom);
        gap_left = gap_left - 1;
      end else if (idle_on && samples_to_send.size() > 0 && $urandom_range(0, 9) == 0) begin
        gap_left = $urandom_range(0, 16);
        s_tvalid <= 1'b0;
        s_tdata <= 24'($urandom);
      end else if (samples_to_send.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= samples_to_send[0];
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    s_taken = 0;
  end

  // Monitor: backpressure and result check
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 16);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [23:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (out_due.size() == 0) begin
        $display("%0t: unexpected result transaction, actual %h", $time, m_tdata);
        errors++;
      end else begin
        want = out_due.pop_front();
        if (m_tdata !== want) begin
          $display("%0t: sample_out mismatch, expected %h, actual %h", $time, want, m_tdata);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("feedback_echo_delay_line_top_tb failed");
      $finish;
    end
  end

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                         input int w);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    // stray bits above the register width must be ignored
    if ($urandom_range(0, 3) == 0) val = val | (junk << w);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    reg_update(idx, val);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (samples_to_send.size() != 0 || out_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic random_setup();
    logic [RATE_W-1:0] rate;
    logic [DELAY_W-1:0] dly;
    logic [CHAN_W-1:0] ch;
    case ($urandom_range(0, 5))
      0: begin rate = 16'd1000; dly = DELAY_W'($urandom_range(0, 12)); end
      1: begin rate = RATE_W'($urandom_range(1, 2000)); dly = DELAY_W'($urandom_range(0, 20)); end
      2: begin rate = 16'd64064; dly = 10'd1023; end  // wraps past the ring for two or more channels
      3: begin rate = 16'd43691; dly = 10'd1000; end
      4: begin rate = 16'd0; dly = DELAY_W'($urandom_range(0, 1023)); end
      default: begin rate = RATE_W'($urandom); dly = DELAY_W'($urandom); end
    endcase
    ch = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : 2'($urandom_range(1, 2));
    if ($urandom_range(0, 4) != 0) put_reg(REG_RATE, rate, RATE_W);
    if ($urandom_range(0, 4) != 0) put_reg(REG_CHANNELS, CFG_DATA_W'(ch), CHAN_W);
    if ($urandom_range(0, 4) != 0) put_reg(REG_DELAY, CFG_DATA_W'(dly), DELAY_W);
    if ($urandom_range(0, 4) != 0) put_reg(REG_FEEDBACK, CFG_DATA_W'(pick_pct()), PCT_W);
    if ($urandom_range(0, 4) != 0) put_reg(REG_VOLUME, CFG_DATA_W'(pick_pct()), PCT_W);
    if ($urandom_range(0, 7) == 0)
      put_reg(CFG_IDX_W'($urandom_range(REG_CHANNELS + 1, REG_IDX_MAX)),
              CFG_DATA_W'($urandom), CFG_DATA_W);
    end_writes();
  endtask

  initial begin
    int random_sent;
    int n;
    random_sent = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // default setup: tap is far back and still empty, output equals input
    samples_to_send.push_back(24'h800000);
    samples_to_send.push_back(24'h7FFFFF);
    samples_to_send.push_back(24'h000000);
    samples_to_send.push_back(24'hFFFFFF);
    samples_to_send.push_back(24'h555555);
    samples_to_send.push_back(24'hAAAAAA);
    samples_to_send.push_back(24'h000001);
    drain();

    // one-sample echo at full gain: saturation both ways
    put_reg(REG_RATE, CFG_DATA_W'(1000), RATE_W);
    put_reg(REG_DELAY, CFG_DATA_W'(1), DELAY_W);
    put_reg(REG_CHANNELS, CFG_DATA_W'(1), CHAN_W);
    put_reg(REG_FEEDBACK, CFG_DATA_W'(100), PCT_W);
    put_reg(REG_VOLUME, CFG_DATA_W'(100), PCT_W);
    end_writes();
    repeat (3) samples_to_send.push_back(24'h7FFFFF);
    repeat (3) samples_to_send.push_back(24'h800000);
    drain();

    // zero delay, percentages above 100
    put_reg(REG_DELAY, CFG_DATA_W'(0), DELAY_W);
    put_reg(REG_FEEDBACK, CFG_DATA_W'(127), PCT_W);
    put_reg(REG_VOLUME, CFG_DATA_W'(127), PCT_W);
    end_writes();
    repeat (3) samples_to_send.push_back(gen_sample());
    drain();

    // distance beyond the ring depth wraps to two
    put_reg(REG_RATE, CFG_DATA_W'(64064), RATE_W);
    put_reg(REG_DELAY, CFG_DATA_W'(1023), DELAY_W);
    put_reg(REG_CHANNELS, CFG_DATA_W'(2), CHAN_W);
    put_reg(REG_VOLUME, CFG_DATA_W'(0), PCT_W);
    end_writes();
    repeat (4) samples_to_send.push_back(gen_sample());
    drain();

    // unused indexes and same-value rate/channel writes leave the ring alone
    put_reg(CFG_IDX_W'(REG_CHANNELS + 1), CFG_DATA_W'($urandom), CFG_DATA_W);
    put_reg(CFG_IDX_W'(REG_IDX_MAX - 1), CFG_DATA_W'($urandom), CFG_DATA_W);
    put_reg(REG_IDX_MAX, CFG_DATA_W'($urandom), CFG_DATA_W);
    put_reg(REG_RATE, CFG_DATA_W'(64064), RATE_W);
    put_reg(REG_CHANNELS, CFG_DATA_W'(2), CHAN_W);
    put_reg(REG_VOLUME, CFG_DATA_W'(50), PCT_W);
    end_writes();
    repeat (3) samples_to_send.push_back(gen_sample());
    drain();

    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent > RANDOM_ITEMS - 110) idle_on = 0;
      random_setup();
      n = $urandom_range(20, 60);
      repeat (n) samples_to_send.push_back(gen_sample());
      random_sent += n;
      drain();
    end

    if (errors == 0) begin
      $display("feedback_echo_delay_line_top_tb passed");
    end else begin
      $display("feedback_echo_delay_line_top_tb failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/fbecho_pkg.sv
hdl/feedback_echo_delay_line_top.sv
bench/feedback_echo_delay_line_top_tb.sv
